FILE: hw/rtl/crufc_pkg.sv
// Package for the three-class union-find claim checker.
// Table sizing constants and sequencer state codes; no dependencies.
package crufc_pkg;
  localparam int MAX_ITEMS = 16384;
  localparam int TBL_DEPTH = 3 * MAX_ITEMS;
  localparam int IDX_W = $clog2(TBL_DEPTH);
  localparam int CNT_W = 15;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ITEMS);
  localparam logic [IDX_W-1:0] COPY_OFS = IDX_W'(MAX_ITEMS);
  localparam logic [IDX_W-1:0] COPY2_OFS = IDX_W'(2 * MAX_ITEMS);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_CLEAR = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] ST_RD_X  = 4'd2;  // read parent of x
  localparam logic [ST_W-1:0] ST_WT_X  = 4'd3;  // parent of x on read port
  localparam logic [ST_W-1:0] ST_WT_P  = 4'd4;  // grandparent on read port
  localparam logic [ST_W-1:0] ST_NEXT  = 4'd5;  // root found, pick next find
  localparam logic [ST_W-1:0] ST_OUT   = 4'd6;

  typedef logic [IDX_W-1:0] idx_t;
endpackage

FILE: hw/rtl/crufc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module crufc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/cyclic_relation_union_find_checker_top.sv
// Top level of the three-class union-find claim checker.
// Uses crufc_pkg and one crufc_ram instance for the parent table.
//
//  channel | ports                                        | handshake
//  in      | in_func, in_first_id, in_second_id           | in_valid/in_ready
//  out     | out_claim_false, out_false_total             | out_valid/out_ready
//  cfg     | cfg_item_count                               | cfg_we, no wait
//
// After reset a clearing pass writes every table entry with its own index;
// no transaction is accepted meanwhile (cfg writes still taken).
// A claim runs up to nine finds one after another on the one parent table;
// a find reads the parent of its node and, per hop, reads the grandparent and
// writes it back as the new parent (path halving). A claim rejected on its ids
// goes straight to the output; one rejected on a contradiction stops early.
// Output is held in a register until taken; the next claim waits for that.
module cyclic_relation_union_find_checker_top
  import crufc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_item_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_first_id,
  input  logic [15:0] in_second_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_claim_false,
  output logic [31:0] out_false_total
);
  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      total_r;
  logic             bad_r;
  logic             func_r;
  idx_t             x0_r, y0_r;
  idx_t             cur_r;      // node being walked
  idx_t             rx_r, ra_r; // root of x0, first root of a join pair
  logic [2:0]       step_r;     // which find in the claim sequence

  logic             we;
  idx_t             wa, wd, ra;
  logic [15:0]      rd16;
  idx_t             rd;

  crufc_ram #(.WIDTH(16), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(16'(wd)),
    .rd_addr(ra), .rd_data(rd16)
  );
  assign rd = rd16[IDX_W-1:0];

  // Find sequence. Check: step0 x0, step1/2 two y copies.
  // step 0: find x0 (rx). 1: find yA. 2: find yB. 3..5: join pairs (a, b)
  // each as two finds, tracked with half_r.
  logic half_r;

  function automatic idx_t node_of(input logic [2:0] s, input logic h, input logic f,
                                   input idx_t x0, input idx_t y0);
    idx_t a, b;
    begin
      a = x0; b = y0;
      case (s)
        3'd0: node_of = x0;
        3'd1: node_of = f ? y0 : y0 + COPY_OFS;
        3'd2: node_of = y0 + COPY2_OFS;
        3'd3: begin a = x0;            b = f ? y0 + COPY_OFS  : y0;
                node_of = h ? b : a; end
        3'd4: begin a = x0 + COPY_OFS; b = f ? y0 + COPY2_OFS : y0 + COPY_OFS;
                node_of = h ? b : a; end
        3'd5: begin a = x0 + COPY2_OFS; b = f ? y0 : y0 + COPY2_OFS;
                node_of = h ? b : a; end
        default: node_of = x0;
      endcase
    end
  endfunction

  logic [15:0] eff_cnt;
  logic        range_bad;
  assign eff_cnt = (count_r > CNT_W'(MAX_ITEMS)) ? 16'(MAX_ITEMS) : 16'(count_r);
  assign range_bad = (in_first_id == 16'd0) || (in_second_id == 16'd0) ||
                     (in_first_id > eff_cnt) || (in_second_id > eff_cnt);

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_claim_false = bad_r;
  assign out_false_total = total_r;

  // Table port control
  always_comb begin
    we = 1'b0; wa = cur_r; wd = rd; ra = rd;
    case (state_r)
      ST_CLEAR: begin we = 1'b1; wa = cur_r; wd = cur_r; end
      ST_RD_X:  ra = cur_r;
      ST_WT_X:  ra = rd;
      ST_WT_P:  begin we = 1'b1; wa = cur_r; wd = rd; ra = rd; end
      ST_NEXT:  if (step_r >= 3'd3 && half_r) begin
                  we = 1'b1; wa = ra_r; wd = cur_r;
                end
      default:  ;
    endcase
  end

  logic [2:0] step_n;
  logic       half_n;
  logic       bad_n;
  logic       done_n;
  always_comb begin
    step_n = step_r; half_n = half_r; bad_n = bad_r; done_n = 1'b0;
    if (step_r == 3'd0) step_n = 3'd1;
    else if (step_r == 3'd1 || step_r == 3'd2) begin
      if (cur_r == rx_r) begin bad_n = 1'b1; done_n = 1'b1; end
      else if (step_r == 3'd2) begin step_n = 3'd3; half_n = 1'b0; end
      else step_n = 3'd2;
    end else begin
      if (!half_r) half_n = 1'b1;
      else if (step_r == 3'd5) done_n = 1'b1;
      else begin step_n = step_r + 3'd1; half_n = 1'b0; end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (cur_r == idx_t'(TBL_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = range_bad || (in_func && in_first_id
                  == in_second_id) ? ST_OUT : ST_RD_X;
      ST_RD_X:  state_nxt = ST_WT_X;
      ST_WT_X:  state_nxt = (rd == cur_r) ? ST_NEXT : ST_WT_P;
      ST_WT_P:  state_nxt = ST_WT_X;
      ST_NEXT:  state_nxt = done_n ? ST_OUT : ST_RD_X;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cur_r   <= '0;
      count_r <= CNT_RESET;
      total_r <= '0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) count_r <= cfg_item_count;
      case (state_r)
        ST_CLEAR: cur_r <= cur_r + idx_t'(1);
        ST_IDLE: if (in_valid) begin
          func_r <= in_func;
          x0_r   <= idx_t'(in_first_id - 16'd1);
          y0_r   <= idx_t'(in_second_id - 16'd1);
          cur_r  <= idx_t'(in_first_id - 16'd1);
          step_r <= 3'd0;
          half_r <= 1'b0;
          bad_r  <= range_bad || (in_func && in_first_id == in_second_id);
          if ((range_bad || (in_func && in_first_id == in_second_id)) &&
              total_r != 32'hFFFF_FFFF) total_r <= total_r + 32'd1;
        end
        ST_WT_P: cur_r <= rd;   // path halving: cur -> grandparent
        ST_NEXT: begin
          if (step_r == 3'd0) rx_r <= cur_r;
          if (step_r >= 3'd3 && !half_r) ra_r <= cur_r;
          step_r <= step_n;
          half_r <= half_n;
          bad_r  <= bad_n;
          if (bad_n && !bad_r && total_r != 32'hFFFF_FFFF) total_r <= total_r + 32'd1;
          cur_r  <= node_of(step_n, half_n, func_r, x0_r, y0_r);
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_false_total))
    else $error("result changed while stalled");
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r)) else $error("total decreased");
  a_clear_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready && !out_valid) else $error("busy clearing");
endmodule

FILE: verif/tb_top.sv
// Testbench for the three-class union-find claim checker.
// Needs crufc_pkg and cyclic_relation_union_find_checker_top; self-checking.
`timescale 1ns / 100ps

module tb_top;
  import crufc_pkg::*;

  typedef struct packed {
    logic        func;
    logic [15:0] first_id;
    logic [15:0] second_id;
  } claim_t;

  typedef struct packed {
    logic        claim_false;
    logic [31:0] false_total;
  } verdict_t;

  // a directed row: claim, whether the verdict is typed in, and that verdict
  typedef struct packed {
    claim_t      c;
    logic        fixed;
    logic        exp_false;
  } row_t;

  localparam logic FN_SAME = 1'b0;
  localparam logic FN_EATS = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_item_count = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [15:0] in_first_id = '0;
  logic [15:0] in_second_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_claim_false;
  logic [31:0] out_false_total;

  cyclic_relation_union_find_checker_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_item_count(cfg_item_count),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_first_id(in_first_id), .in_second_id(in_second_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_claim_false(out_claim_false), .out_false_total(out_false_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned forest[TBL_DEPTH];
  logic [31:0] rejected_total;
  logic [14:0] id_limit;

  verdict_t    pending_verdicts[$];
  int          fail_count = 0;
  int          verdicts_seen = 0;
  int          rejects_seen = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  function automatic int unsigned root_of(int unsigned x);
    int unsigned p;
    while (forest[x] != x) begin
      p = forest[forest[x]];
      forest[x] = p;
      x = p;
    end
    return x;
  endfunction

  function automatic void merge_sets(int unsigned a, int unsigned b);
    int unsigned ra;
    ra = root_of(a);
    forest[ra] = root_of(b);
  endfunction

  function automatic verdict_t judge_claim(claim_t c);
    int unsigned lim, x0, y0, rx, m;
    logic bad;
    verdict_t v;
    m = MAX_ITEMS;
    lim = (id_limit > m) ? m : id_limit;
    bad = 1'b0;
    if (c.first_id == 0 || c.second_id == 0 || c.first_id > lim || c.second_id > lim) begin
      bad = 1'b1;
    end else begin
      x0 = c.first_id - 1;
      y0 = c.second_id - 1;
      rx = root_of(x0);
      if (c.func == FN_SAME) begin
        if (rx == root_of(y0 + m) || rx == root_of(y0 + 2 * m)) begin
          bad = 1'b1;
        end else begin
          merge_sets(x0, y0);
          merge_sets(x0 + m, y0 + m);
          merge_sets(x0 + 2 * m, y0 + 2 * m);
        end
      end else begin
        if (c.first_id == c.second_id || rx == root_of(y0) || rx == root_of(y0 + 2 * m)) begin
          bad = 1'b1;
        end else begin
          merge_sets(x0, y0 + m);
          merge_sets(x0 + m, y0 + 2 * m);
          merge_sets(x0 + 2 * m, y0);
        end
      end
    end
    if (bad && rejected_total != 32'hFFFF_FFFF) rejected_total++;
    v.claim_false = bad;
    v.false_total = rejected_total;
    return v;
  endfunction

  task automatic pause_random(int long_pct);
    int n;
    if ($urandom_range(99) < 30) return;
    n = ($urandom_range(99) < long_pct) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    repeat (n) @(negedge clk);
  endtask

  // drives change only at the falling edge, so blocking updates are safe here
  task automatic offer_claim(claim_t c, logic fixed, logic exp_false);
    verdict_t v;
    in_valid = 1'b1;
    in_func = c.func;
    in_first_id = c.first_id;
    in_second_id = c.second_id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = judge_claim(c);
    if (fixed && v.claim_false !== exp_false) begin
      $display("%0t: directed row disagrees: expected %0b predicted %0b",
               $time, exp_false, v.claim_false);
      fail_count++;
    end
    pending_verdicts.push_back(v);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_limit(logic [14:0] val);
    wait (pending_verdicts.size() == 0);
    repeat (200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_item_count <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    id_limit = val;
  endtask

  function automatic claim_t rand_claim(int unsigned lim);
    claim_t c;
    c.func = 1'($urandom_range(1));
    case ($urandom_range(19))
      0: c.first_id = 16'($urandom_range(16'hFFFF));
      1: c.first_id = 16'd0;
      default: c.first_id = 16'($urandom_range(lim, 1));
    endcase
    case ($urandom_range(19))
      0: c.second_id = 16'($urandom_range(16'hFFFF));
      1: c.second_id = c.first_id;
      default: c.second_id = 16'($urandom_range(lim, 1));
    endcase
    return c;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) < 70);
    end
  end

  initial begin : hold_off_proc
    wait (verdicts_seen == 400);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.claim_false = out_claim_false;
      got.false_total = out_false_total;
      verdicts_seen++;
      if (got.claim_false) rejects_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected transaction, actual %0b/%0d", $time,
                 got.claim_false, got.false_total);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.claim_false !== want.claim_false) begin
          $display("%0t: claim_false expected %0b actual %0b", $time,
                   want.claim_false, got.claim_false);
          fail_count++;
        end
        if (got.false_total !== want.false_total) begin
          $display("%0t: false_total expected %0d actual %0d", $time,
                   want.false_total, got.false_total);
          fail_count++;
        end
      end
    end
  end

  row_t directed[] = '{
    '{'{FN_SAME, 16'd0, 16'd1}, 1'b1, 1'b1},
    '{'{FN_EATS, 16'd1, 16'd0}, 1'b1, 1'b1},
    '{'{FN_SAME, 16'd16385, 16'd1}, 1'b1, 1'b1},
    '{'{FN_EATS, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b1},
    '{'{FN_EATS, 16'd5, 16'd5}, 1'b1, 1'b1},
    '{'{FN_SAME, 16'd5, 16'd5}, 1'b1, 1'b0},
    '{'{FN_SAME, 16'd1, 16'd16384}, 1'b1, 1'b0},
    '{'{FN_EATS, 16'd1, 16'd2}, 1'b1, 1'b0},
    '{'{FN_EATS, 16'd2, 16'd3}, 1'b0, 1'b0},
    '{'{FN_EATS, 16'd3, 16'd1}, 1'b0, 1'b0},
    '{'{FN_SAME, 16'd1, 16'd2}, 1'b0, 1'b0},
    '{'{FN_EATS, 16'd2, 16'd1}, 1'b0, 1'b0},
    '{'{FN_EATS, 16'd1, 16'd3}, 1'b0, 1'b0},
    '{'{FN_SAME, 16'd16384, 16'd2}, 1'b0, 1'b0},
    '{'{FN_EATS, 16'h8AAA, 16'h5555}, 1'b1, 1'b1}
  };

  initial begin : stimulus
    claim_t c;
    int unsigned lim;
    for (int i = 0; i < TBL_DEPTH; i++) forest[i] = i;
    rejected_total = '0;
    id_limit = CNT_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      offer_claim(directed[i].c, directed[i].fixed, directed[i].exp_false);
      pause_random(5);
    end

    // mostly small counts so claims collide often, mixed with the extremes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_limit(15'd1);
        1: write_limit(15'd0);
        2: write_limit(15'd20);
        3: write_limit(15'h7FFF);
        4: write_limit(15'd60);
        default: write_limit(15'd16384);
      endcase
      lim = (id_limit == 0) ? 1 : ((id_limit > MAX_ITEMS) ? MAX_ITEMS : id_limit);
      for (int k = 0; k < ((phase == 4) ? 500 : 160); k++) begin
        c = rand_claim(lim);
        offer_claim(c, 1'b0, 1'b0);
        if (k % 40 >= 20) pause_random(5);
      end
    end
    write_limit(15'd200);
    stim_done = 1'b1;

    wait (pending_verdicts.size() == 0);
    repeat (200) @(negedge clk);
    $display("Checked %0d verdicts (%0d rejected) across counts 0..32767,",
             verdicts_seen, rejects_seen);
    $display("with random stalls and one long output hold-off.");
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/crufc_pkg.sv
hw/rtl/crufc_ram.sv
hw/rtl/cyclic_relation_union_find_checker_top.sv
verif/tb_top.sv
